// ----- src/md5_pkg.sv -----
// shared types, constants and round helpers of the md5 hash engine
package md5_pkg;

  // one 64-byte block: 16 little-endian words of 4 bytes
  typedef logic [15:0][3:0][7:0] blk_t;

  // chaining words or working words, index 0 = a
  typedef logic [3:0][31:0] chain_t;

  // push side of the block queue
  typedef struct packed {
    logic push;
    logic fin;
    blk_t blk;
  } qpush_t;

  // head side of the block queue
  typedef struct packed {
    logic valid;
    logic fin;
    blk_t blk;
  } qhead_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_FULL,
    F_MARK,
    F_SPILL,
    F_LEN
  } front_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_ADD,
    C_OUT
  } core_state_t;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] SPILL_POS  = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [1:0] LAST_WIDX  = 2'd3;

  localparam chain_t IV_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam logic [31:0] K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
    return (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

  // message word used by a round
  function automatic logic [3:0] msg_idx(input logic [5:0] r);
    logic [3:0] idx;
    case (r[5:4])
      2'd0:    idx = r[3:0];
      2'd1:    idx = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2:    idx = 4'(r[3:0] * 4'd3 + 4'd5);
      default: idx = 4'(r[3:0] * 4'd7);
    endcase
    return idx;
  endfunction

endpackage

// ----- src/md5_chan_if.sv -----
// valid/ready channel interfaces for message bytes and digest words
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output has_byte, output is_last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input is_last,
                output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ----- src/md5_front.sv -----
// byte packer and padding sequencer feeding the block queue
module md5_front (
  input  logic            clk,
  input  logic            rst_n,
  md5_in_if.sink          in_if,
  input  logic            q_full,
  output md5_pkg::qpush_t q_push
);

  md5_pkg::front_state_t state_r, state_nxt;
  md5_pkg::blk_t         buf_r, buf_nxt;
  logic [5:0]            pos_r, pos_nxt;
  logic [63:0]           len_r, len_nxt;
  logic                  last_r, last_nxt;
  logic                  acc;

  assign acc = in_if.valid && in_if.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      md5_pkg::F_IDLE: begin
        if (acc) begin
          if (in_if.has_byte && pos_r == md5_pkg::LAST_POS) begin
            state_nxt = md5_pkg::F_FULL;
          end else if (in_if.is_last) begin
            state_nxt = md5_pkg::F_MARK;
          end
        end
      end
      md5_pkg::F_FULL: begin
        if (!q_full) begin
          state_nxt = last_r ? md5_pkg::F_MARK : md5_pkg::F_IDLE;
        end
      end
      md5_pkg::F_MARK: begin
        state_nxt = (pos_r >= md5_pkg::SPILL_POS) ? md5_pkg::F_SPILL : md5_pkg::F_LEN;
      end
      md5_pkg::F_SPILL: begin
        if (!q_full) begin
          state_nxt = md5_pkg::F_LEN;
        end
      end
      md5_pkg::F_LEN: begin
        if (!q_full) begin
          state_nxt = md5_pkg::F_IDLE;
        end
      end
      default: state_nxt = md5_pkg::F_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_if.ready = (state_r == md5_pkg::F_IDLE);
    buf_nxt     = buf_r;
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    last_nxt    = last_r;
    q_push.push = 1'b0;
    q_push.fin  = 1'b0;
    q_push.blk  = buf_r;
    case (state_r)
      md5_pkg::F_IDLE: begin
        if (acc) begin
          last_nxt = in_if.is_last;
          if (in_if.has_byte) begin
            buf_nxt[pos_r[5:2]][pos_r[1:0]] = in_if.data_byte;
            pos_nxt = pos_r + 6'd1;
            len_nxt = len_r + 64'd8;
          end
        end
      end
      md5_pkg::F_FULL, md5_pkg::F_SPILL: begin
        if (!q_full) begin
          q_push.push = 1'b1;
          buf_nxt     = '0;
          pos_nxt     = '0;
        end
      end
      md5_pkg::F_MARK: begin
        buf_nxt[pos_r[5:2]][pos_r[1:0]] = md5_pkg::PAD_MARK;
        pos_nxt = pos_r + 6'd1;
      end
      md5_pkg::F_LEN: begin
        q_push.blk[14] = len_r[31:0];
        q_push.blk[15] = len_r[63:32];
        q_push.fin     = 1'b1;
        if (!q_full) begin
          q_push.push = 1'b1;
          buf_nxt     = '0;
          pos_nxt     = '0;
          len_nxt     = '0;
          last_nxt    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md5_pkg::F_IDLE;
      buf_r   <= '0;
      pos_r   <= '0;
      len_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      buf_r   <= buf_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// ----- src/md5_blkq.sv -----
// short queue of full blocks between the packer and the round engine
module md5_blkq #(
  parameter int DEPTH = md5_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  md5_pkg::qpush_t q_push,
  input  logic            q_pop,
  output logic            q_full,
  output md5_pkg::qhead_t q_head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  md5_pkg::blk_t mem_r [DEPTH];
  logic          fin_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;
  logic          push_ok, pop_ok;

  assign q_full       = (cnt_r == CW'(DEPTH));
  assign push_ok      = q_push.push && !q_full;
  assign pop_ok       = q_pop && (cnt_r != '0);
  assign q_head.valid = (cnt_r != '0);
  assign q_head.fin   = fin_r[rptr_r];
  assign q_head.blk   = mem_r[rptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wptr_r] <= q_push.blk;
      fin_r[wptr_r] <= q_push.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push_ok) begin
        wptr_r <= ptr_inc(wptr_r);
      end
      if (pop_ok) begin
        rptr_r <= ptr_inc(rptr_r);
      end
      case ({push_ok, pop_ok})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- src/md5_core.sv -----
// md5 round engine: one round per cycle, chaining fold and digest output
module md5_core (
  input  logic            clk,
  input  logic            rst_n,
  input  md5_pkg::qhead_t q_head,
  output logic            q_pop,
  md5_out_if.source       out_if
);

  md5_pkg::core_state_t state_r, state_nxt;
  md5_pkg::chain_t      chain_r, chain_nxt;
  md5_pkg::chain_t      regs_r, regs_nxt;
  logic [5:0]           rnd_r, rnd_nxt, rnd_inc;
  logic [31:0]          km_r, km_nxt;
  logic                 fin_r, fin_nxt;
  logic [1:0]           widx_r, widx_nxt;
  logic [31:0]          f_val, sum_val, new_b;

  assign rnd_inc = rnd_r + 6'd1;

  // round function
  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f_val = (regs_r[1] & regs_r[2]) | (~regs_r[1] & regs_r[3]);
      2'd1:    f_val = (regs_r[1] & regs_r[3]) | (regs_r[2] & ~regs_r[3]);
      2'd2:    f_val = regs_r[1] ^ regs_r[2] ^ regs_r[3];
      default: f_val = regs_r[2] ^ (regs_r[1] | ~regs_r[3]);
    endcase
    sum_val = regs_r[0] + f_val + km_r;
    new_b   = regs_r[1] + md5_pkg::rotl32(sum_val, md5_pkg::ROT_TAB[{rnd_r[5:4], rnd_r[1:0]}]);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      md5_pkg::C_IDLE: begin
        if (q_head.valid) begin
          state_nxt = md5_pkg::C_ROUND;
        end
      end
      md5_pkg::C_ROUND: begin
        if (rnd_r == md5_pkg::LAST_ROUND) begin
          state_nxt = md5_pkg::C_ADD;
        end
      end
      md5_pkg::C_ADD: begin
        state_nxt = fin_r ? md5_pkg::C_OUT : md5_pkg::C_IDLE;
      end
      md5_pkg::C_OUT: begin
        if (out_if.ready && widx_r == md5_pkg::LAST_WIDX) begin
          state_nxt = md5_pkg::C_IDLE;
        end
      end
      default: state_nxt = md5_pkg::C_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop              = (state_r == md5_pkg::C_ROUND) && (rnd_r == md5_pkg::LAST_ROUND);
    out_if.valid       = (state_r == md5_pkg::C_OUT);
    out_if.digest_word = chain_r[widx_r];
    out_if.word_index  = widx_r;
    out_if.last_word   = (widx_r == md5_pkg::LAST_WIDX);
  end

  // datapath
  always_comb begin
    chain_nxt = chain_r;
    regs_nxt  = regs_r;
    rnd_nxt   = rnd_r;
    km_nxt    = km_r;
    fin_nxt   = fin_r;
    widx_nxt  = widx_r;
    case (state_r)
      md5_pkg::C_IDLE: begin
        if (q_head.valid) begin
          regs_nxt = chain_r;
          rnd_nxt  = '0;
          km_nxt   = md5_pkg::K_TAB[0] + q_head.blk[md5_pkg::msg_idx(6'd0)];
          fin_nxt  = q_head.fin;
        end
      end
      md5_pkg::C_ROUND: begin
        regs_nxt[0] = regs_r[3];
        regs_nxt[1] = new_b;
        regs_nxt[2] = regs_r[1];
        regs_nxt[3] = regs_r[2];
        rnd_nxt     = rnd_inc;
        km_nxt      = md5_pkg::K_TAB[rnd_inc] + q_head.blk[md5_pkg::msg_idx(rnd_inc)];
      end
      md5_pkg::C_ADD: begin
        for (int i = 0; i < 4; i++) begin
          chain_nxt[i] = chain_r[i] + regs_r[i];
        end
        widx_nxt = '0;
      end
      md5_pkg::C_OUT: begin
        if (out_if.ready) begin
          widx_nxt = widx_r + 2'd1;
          if (widx_r == md5_pkg::LAST_WIDX) begin
            chain_nxt = md5_pkg::IV_INIT;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    regs_r <= regs_nxt;
    km_r   <= km_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md5_pkg::C_IDLE;
      chain_r <= md5_pkg::IV_INIT;
      rnd_r   <= '0;
      fin_r   <= 1'b0;
      widx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      rnd_r   <= rnd_nxt;
      fin_r   <= fin_nxt;
      widx_r  <= widx_nxt;
    end
  end

endmodule

// ----- src/md5_hash_engine_unit.sv -----
// top level of the streaming md5 hash engine
// usage:
//   in_if carries one beat per message byte (data_byte, has_byte) with is_last
//   on the final beat; a beat with has_byte low and is_last high ends a message
//   without adding a byte, and a beat with both low does nothing
//   out_if gives four beats per message, chaining words a, b, c, d in order,
//   word_index 0..3 and last_word on the d word; each word's bytes low first
// throughput:
//   the packer takes one byte per cycle while in_if.ready is high and hands each
//   full 64-byte block to the queue in a separate state; the round engine
//   loads each block, runs its 64 rounds and folds the result, so a long message
//   is limited by the round loop; the block queue lets packing of the next
//   block overlap the rounds of the current one
// after the last beat:
//   padding writes the pad mark and the length, then one or two blocks run
//   through the round engine, then the digest beats start
// reset: synchronous, active low; the chaining words return to the standard
//   initial vector and all counters and the queue clear
// stall: with out_if.ready low the digest word holds; the round engine waits,
//   the queue fills and in_if.ready then drops in the packer
module md5_hash_engine_unit #(
  parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  md5_in_if.sink     in_if,
  md5_out_if.source  out_if
);

  // block queue handshake between packer and round engine
  md5_pkg::qpush_t q_push;
  md5_pkg::qhead_t q_head;
  logic            q_full;
  logic            q_pop;

  // front: byte packing, length count and padding
  md5_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push)
  );

  // queue of complete blocks
  md5_blkq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_blkq (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_full (q_full),
    .q_head (q_head)
  );

  // back: compression rounds and digest beats
  md5_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_if (out_if)
  );

endmodule

// ----- src/md5_chk.sv -----
// port-level checks of the md5 hash engine and their binding
module md5_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_is_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [1:0]  out_word_index,
  input logic        out_last_word
);

  // last_word marks exactly the d word
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 2'd3)))
    else $error("last_word does not match word_index");

  // digest words follow in order without gaps
  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_word_index != 2'd3 |=>
      out_valid && out_word_index == $past(out_word_index) + 2'd1)
    else $error("digest beats out of sequence");

  // a stalled digest beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_digest_word) && $stable(out_word_index))
    else $error("digest beat changed while stalled");

  // the end of a message blocks new bytes as padding starts
  a_pad_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> !in_ready)
    else $error("input taken during padding");

  // reset leaves no digest beat pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("digest beat right after reset");

endmodule

bind md5_hash_engine_unit md5_chk u_md5_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .in_is_last      (in_if.is_last),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_digest_word (out_if.digest_word),
  .out_word_index  (out_if.word_index),
  .out_last_word   (out_if.last_word)
);
